### rtl/lsch_pkg.sv
`default_nettype none

package lsch_pkg;

  // table geometry
  localparam int SLOT_COUNT  = 64;
  localparam int TICKET_BITS = 8;
  localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
  localparam int WALK_BITS   = SLOT_BITS + 1;
  localparam int SUM_BITS    = SLOT_BITS + TICKET_BITS;

  // fixed field widths
  localparam int IDX_W   = 6;
  localparam int TKT_W   = 8;
  localparam int RAND_W  = 16;
  localparam int COUNT_W = 32;
  localparam int TOTAL_W = 14;
  localparam int STEP_W  = $clog2(RAND_W);

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_DRAW  = 1'b1;

  // slot memory controls
  typedef struct packed {
    logic                   tkt_we;
    logic [SLOT_BITS-1:0]   tkt_waddr;
    logic [TICKET_BITS-1:0] tkt_wdata;
    logic [SLOT_BITS-1:0]   tkt_raddr;
    logic                   cnt_we;
    logic [SLOT_BITS-1:0]   cnt_addr;
    logic [COUNT_W-1:0]     cnt_wdata;
  } mem_ctrl_t;

  // modulo unit status
  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

`default_nettype wire

### rtl/lsch_if.sv
`default_nettype none

interface lsch_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [lsch_pkg::IDX_W-1:0]  slot_index;
  logic                      set_runnable;
  logic [lsch_pkg::TKT_W-1:0]  set_tickets;
  logic [lsch_pkg::RAND_W-1:0] random_value;

  modport source (
    output valid, req_type, slot_index, set_runnable, set_tickets, random_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, slot_index, set_runnable, set_tickets, random_value,
    output ready
  );
endinterface

interface lsch_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        granted;
  logic [lsch_pkg::IDX_W-1:0]    winner_slot;
  logic [lsch_pkg::COUNT_W-1:0]  winner_count;
  logic [lsch_pkg::TOTAL_W-1:0]  ticket_total;

  modport source (
    output valid, granted, winner_slot, winner_count, ticket_total,
    input  ready
  );
  modport sink (
    input  valid, granted, winner_slot, winner_count, ticket_total,
    output ready
  );
endinterface

`default_nettype wire

### rtl/lsch_slot_mem.sv
`default_nettype none

module lsch_slot_mem (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire lsch_pkg::mem_ctrl_t                  ctrl,
  output logic      [lsch_pkg::TICKET_BITS-1:0]     tkt_rdata,
  output logic      [lsch_pkg::COUNT_W-1:0]         cnt_rdata
);

  logic [lsch_pkg::TICKET_BITS-1:0] tkt_mem [lsch_pkg::SLOT_COUNT];
  logic [lsch_pkg::COUNT_W-1:0]     cnt_mem [lsch_pkg::SLOT_COUNT];
  logic [lsch_pkg::SLOT_COUNT-1:0]  cnt_valid;
  logic [lsch_pkg::COUNT_W-1:0]     cnt_q;
  logic                             cnt_vld_q;

  // ticket memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.tkt_we) begin
      tkt_mem[ctrl.tkt_waddr] <= ctrl.tkt_wdata;
    end
    tkt_rdata <= tkt_mem[ctrl.tkt_raddr];
  end

  // selection counts, single port read or write
  always_ff @(posedge clk) begin
    if (ctrl.cnt_we) begin
      cnt_mem[ctrl.cnt_addr] <= ctrl.cnt_wdata;
    end else begin
      cnt_q <= cnt_mem[ctrl.cnt_addr];
    end
  end

  // per-entry valid bits, unwritten counts read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
      cnt_vld_q <= 1'b0;
    end else if (ctrl.cnt_we) begin
      cnt_valid[ctrl.cnt_addr] <= 1'b1;
    end else begin
      cnt_vld_q <= cnt_valid[ctrl.cnt_addr];
    end
  end

  assign cnt_rdata = cnt_vld_q ? cnt_q : '0;

endmodule

`default_nettype wire

### rtl/lsch_mod_unit.sv
`default_nettype none

module lsch_mod_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [lsch_pkg::RAND_W-1:0]       dividend,
  input  wire logic [lsch_pkg::SUM_BITS-1:0]     divisor,
  output lsch_pkg::mod_stat_t                    stat,
  output logic      [lsch_pkg::SUM_BITS-1:0]     rem
);

  logic [lsch_pkg::RAND_W-1:0]   shreg;
  logic [lsch_pkg::SUM_BITS-1:0] dvs;
  logic [lsch_pkg::STEP_W-1:0]   step;
  logic                          busy;
  logic                          done;
  logic [lsch_pkg::SUM_BITS:0]   trial;
  logic [lsch_pkg::SUM_BITS:0]   diff;

  // one restoring step: shift in next dividend bit, subtract if it fits
  assign trial = {rem, shreg[lsch_pkg::RAND_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      if (start) begin
        busy  <= 1'b1;
        done  <= 1'b0;
        step  <= '0;
        shreg <= dividend;
        dvs   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        shreg <= {shreg[lsch_pkg::RAND_W-2:0], 1'b0};
        if (!diff[lsch_pkg::SUM_BITS]) begin
          rem <= diff[lsch_pkg::SUM_BITS-1:0];
        end else begin
          rem <= trial[lsch_pkg::SUM_BITS-1:0];
        end
        step <= step + 1'b1;
        // done pulses for one cycle after the last step
        done <= (step == lsch_pkg::STEP_W'(lsch_pkg::RAND_W - 1));
        if (step == lsch_pkg::STEP_W'(lsch_pkg::RAND_W - 1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

### rtl/lottery_scheduler_core.sv
`default_nettype none

// channel   dir  handshake     payload
// req       in   valid/ready   req_type, slot_index, set_runnable, set_tickets, random_value
// rsp       out  valid/ready   granted, winner_slot, winner_count, ticket_total
//
// a write request updates the slot and gives no response
// a draw keeps req.ready low while it makes a sum pass and a select pass over
// the ticket memory read port, plus a 16-step restoring modulo; with no runnable
// tickets it skips the modulo and the select pass
// req.ready is high only while the sequencer is idle
// the response sits in an output register; a new request is taken while it waits,
// and a later draw stalls in its last state until that register frees up
// synchronous reset clears runnable flags, count valid bits and control state

module lottery_scheduler_core (
  input  wire logic clk,
  input  wire logic rst,
  lsch_req_if.sink  req,
  lsch_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MOD,
    S_SEL,
    S_CNT_RD,
    S_DONE
  } state_t;

  state_t                            state;
  logic [lsch_pkg::SLOT_COUNT-1:0]   runnable;
  logic [lsch_pkg::WALK_BITS-1:0]    walk_cnt;
  logic                              rd_vld;
  logic [lsch_pkg::SLOT_BITS-1:0]    rd_idx;
  logic [lsch_pkg::SUM_BITS-1:0]     acc;
  logic [lsch_pkg::SUM_BITS-1:0]     draw;
  logic [lsch_pkg::RAND_W-1:0]       rand_q;
  logic [lsch_pkg::SLOT_BITS-1:0]    winner;
  logic                              res_grant;

  logic                              out_valid;
  logic                              out_granted;
  logic [lsch_pkg::IDX_W-1:0]        out_slot;
  logic [lsch_pkg::COUNT_W-1:0]      out_count;
  logic [lsch_pkg::TOTAL_W-1:0]      out_total;

  lsch_pkg::mem_ctrl_t               mem_ctrl;
  lsch_pkg::mod_stat_t               mod_stat;
  logic [lsch_pkg::TICKET_BITS-1:0]  tkt_rdata;
  logic [lsch_pkg::COUNT_W-1:0]      cnt_rdata;
  logic [lsch_pkg::SUM_BITS-1:0]     mod_rem;
  logic                              mod_start;

  logic                              req_fire;
  logic                              wr_ok;
  logic [lsch_pkg::SLOT_BITS-1:0]    wr_addr;
  logic                              walk_end;
  logic                              slot_live;
  logic [lsch_pkg::SUM_BITS-1:0]     tkt_ext;
  logic                              can_load;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign wr_ok     = int'(req.slot_index) < lsch_pkg::SLOT_COUNT;
  assign wr_addr   = lsch_pkg::SLOT_BITS'(req.slot_index);
  assign walk_end  = (walk_cnt == lsch_pkg::WALK_BITS'(lsch_pkg::SLOT_COUNT));
  assign slot_live = rd_vld && runnable[rd_idx];
  assign tkt_ext   = lsch_pkg::SUM_BITS'(tkt_rdata);
  assign can_load  = !out_valid || rsp.ready;
  assign mod_start = (state == S_SUM) && walk_end && !rd_vld && (acc != '0);

  // memory controls
  always_comb begin
    mem_ctrl.tkt_we    = req_fire && (req.req_type == lsch_pkg::REQ_WRITE) && wr_ok;
    mem_ctrl.tkt_waddr = wr_addr;
    mem_ctrl.tkt_wdata = lsch_pkg::TICKET_BITS'(req.set_tickets);
    mem_ctrl.tkt_raddr = walk_cnt[lsch_pkg::SLOT_BITS-1:0];
    mem_ctrl.cnt_we    = (state == S_DONE) && res_grant && can_load;
    mem_ctrl.cnt_addr  = winner;
    mem_ctrl.cnt_wdata = cnt_rdata + 1'b1;
  end

  lsch_slot_mem u_mem (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mem_ctrl),
    .tkt_rdata (tkt_rdata),
    .cnt_rdata (cnt_rdata)
  );

  lsch_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (rand_q),
    .divisor  (acc),
    .stat     (mod_stat),
    .rem      (mod_rem)
  );

  // sequencer, slot flags and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      runnable  <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
      walk_cnt  <= '0;
      res_grant <= 1'b0;
    end else begin
      // response valid: set on load, cleared once taken
      if ((state == S_DONE) && can_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          rd_vld   <= 1'b0;
          walk_cnt <= '0;
          acc      <= '0;
          if (req_fire) begin
            if (req.req_type == lsch_pkg::REQ_DRAW) begin
              rand_q <= req.random_value;
              state  <= S_SUM;
            end else if (wr_ok) begin
              runnable[wr_addr] <= req.set_runnable;
            end
          end
        end
        S_SUM: begin
          // issue one read a cycle, accumulate the data of the previous read
          rd_vld <= !walk_end;
          rd_idx <= walk_cnt[lsch_pkg::SLOT_BITS-1:0];
          if (!walk_end) begin
            walk_cnt <= walk_cnt + 1'b1;
          end
          if (slot_live) begin
            acc <= acc + tkt_ext;
          end
          if (walk_end && !rd_vld) begin
            if (acc == '0) begin
              res_grant <= 1'b0;
              state     <= S_DONE;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          walk_cnt <= '0;
          rd_vld   <= 1'b0;
          if (mod_stat.done) begin
            draw  <= mod_rem + 1'b1;
            state <= S_SEL;
          end
        end
        S_SEL: begin
          // walk again, subtracting tickets until one slot covers the draw
          rd_vld <= !walk_end;
          rd_idx <= walk_cnt[lsch_pkg::SLOT_BITS-1:0];
          if (!walk_end) begin
            walk_cnt <= walk_cnt + 1'b1;
          end
          if (slot_live && (draw <= tkt_ext)) begin
            winner    <= rd_idx;
            res_grant <= 1'b1;
            state     <= S_CNT_RD;
          end else begin
            if (slot_live) begin
              draw <= draw - tkt_ext;
            end
            if (walk_end && !rd_vld) begin
              res_grant <= 1'b0;
              state     <= S_DONE;
            end
          end
        end
        S_CNT_RD: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (can_load) begin
            out_granted <= res_grant;
            if (res_grant) begin
              out_slot         <= lsch_pkg::IDX_W'(winner);
              out_count        <= cnt_rdata + 1'b1;
              out_total        <= lsch_pkg::TOTAL_W'(acc);
              runnable[winner] <= 1'b0;
            end else begin
              out_slot  <= '0;
              out_count <= '0;
              out_total <= lsch_pkg::TOTAL_W'(acc);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.granted      = out_granted;
  assign rsp.winner_slot  = out_slot;
  assign rsp.winner_count = out_count;
  assign rsp.ticket_total = out_total;

  // checks
  a_nogrant_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.granted) |-> (rsp.winner_slot == '0 && rsp.winner_count == '0))
    else $error("non-granted response carries a winner");

  a_draw_positive: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEL) |-> (draw != '0))
    else $error("remaining draw reached zero during select");

  a_write_lands: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.req_type == lsch_pkg::REQ_WRITE && wr_ok)
      |=> (runnable[$past(wr_addr)] == $past(req.set_runnable)))
    else $error("slot write did not update runnable flag");

  a_mod_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mod_stat.busy)
    else $error("modulo unit busy while sequencer idle");

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // request and grant as seen on the channels
  typedef struct packed {
    logic                         req_type;
    logic [lsch_pkg::IDX_W-1:0]   slot_index;
    logic                         set_runnable;
    logic [lsch_pkg::TKT_W-1:0]   set_tickets;
    logic [lsch_pkg::RAND_W-1:0]  random_value;
  } sched_req_t;

  typedef struct packed {
    logic                         granted;
    logic [lsch_pkg::IDX_W-1:0]   winner_slot;
    logic [lsch_pkg::COUNT_W-1:0] winner_count;
    logic [lsch_pkg::TOTAL_W-1:0] ticket_total;
  } grant_t;

  // one row of the directed table; fixed marks a grant typed in by hand
  typedef struct packed {
    sched_req_t req;
    logic       fixed;
    grant_t     want;
  } dir_row_t;

  typedef enum int {MIX_SPARSE, MIX_HEAVY, MIX_FILL, MIX_NOISE} mix_t;

  localparam grant_t NO_GRANT    = '0;
  localparam int     DIR_ROWS    = 24;
  localparam int     ITEM_TARGET = 1700;
  localparam int     CALM_ITEMS  = 200;
  localparam int     PHASE_ITEMS = 100;
  localparam int     HOLD_CYCLES = 1200;
  localparam int     DRAIN_TAIL  = 200;

  logic clk = 1'b0;
  logic rst;

  lsch_req_if req_bus ();
  lsch_rsp_if rsp_bus ();

  lottery_scheduler_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the slot table
  logic                         slot_runnable [lsch_pkg::SLOT_COUNT];
  logic [lsch_pkg::TKT_W-1:0]   slot_tickets  [lsch_pkg::SLOT_COUNT];
  logic [lsch_pkg::COUNT_W-1:0] slot_picks    [lsch_pkg::SLOT_COUNT];

  grant_t pending_grants [$];
  int     error_count  = 0;
  int     issued       = 0;
  bit     calm         = 1'b0;
  bit     hold_request = 1'b0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // empty table right after reset, write fields ignored on a draw
    '{'{lsch_pkg::REQ_DRAW,  6'h3F, 1'b1, 8'hFF,  16'hFFFF}, 1'b1, NO_GRANT},
    '{'{lsch_pkg::REQ_WRITE, 6'd0,  1'b1, 8'hFF,  16'hFFFF}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_WRITE, 6'd63, 1'b1, 8'hFF,  16'h0000}, 1'b0, NO_GRANT},
    // runnable but holding no tickets
    '{'{lsch_pkg::REQ_WRITE, 6'd5,  1'b1, 8'h00,  16'h1234}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_WRITE, 6'd10, 1'b0, 8'd200, 16'h0000}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_DRAW,  6'd0,  1'b0, 8'h00,  16'h0000}, 1'b1,
      '{1'b1, 6'd0, 32'd1, 14'd510}},
    '{'{lsch_pkg::REQ_DRAW,  6'd0,  1'b0, 8'h00,  16'hFFFF}, 1'b1,
      '{1'b1, 6'd63, 32'd1, 14'd255}},
    // only a zero-ticket slot left runnable
    '{'{lsch_pkg::REQ_DRAW,  6'h2A, 1'b1, 8'h81,  16'h1234}, 1'b1, NO_GRANT},
    '{'{lsch_pkg::REQ_WRITE, 6'd10, 1'b1, 8'd1,   16'h0000}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_WRITE, 6'd20, 1'b1, 8'd1,   16'h0000}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_DRAW,  6'd0,  1'b0, 8'h00,  16'h0001}, 1'b1,
      '{1'b1, 6'd20, 32'd1, 14'd2}},
    '{'{lsch_pkg::REQ_DRAW,  6'd0,  1'b0, 8'h00,  16'h0000}, 1'b1,
      '{1'b1, 6'd10, 32'd1, 14'd1}},
    '{'{lsch_pkg::REQ_WRITE, 6'd0,  1'b1, 8'hFF,  16'h0000}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_DRAW,  6'd0,  1'b0, 8'h00,  16'h8000}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_WRITE, 6'd33, 1'b1, 8'h55,  16'hAAAA}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_WRITE, 6'd34, 1'b1, 8'hAA,  16'h5555}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_WRITE, 6'd5,  1'b1, 8'h01,  16'h0000}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_DRAW,  6'h15, 1'b1, 8'h55,  16'h5555}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_DRAW,  6'h2A, 1'b0, 8'hAA,  16'hAAAA}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_DRAW,  6'd0,  1'b0, 8'h00,  16'h0003}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_DRAW,  6'd0,  1'b0, 8'h00,  16'hFFFF}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_WRITE, 6'd33, 1'b0, 8'h00,  16'h0000}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_DRAW,  6'd0,  1'b0, 8'h00,  16'h7FFF}, 1'b0, NO_GRANT},
    '{'{lsch_pkg::REQ_DRAW,  6'd0,  1'b0, 8'h00,  16'h0001}, 1'b0, NO_GRANT}
  };

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // apply a request to the shadow table; a draw returns its grant
  function automatic bit run_lottery(input sched_req_t r, output grant_t g);
    int unsigned total;
    int unsigned pick;
    int          i;
    g     = NO_GRANT;
    total = 0;
    if (r.req_type == lsch_pkg::REQ_WRITE) begin
      slot_runnable[r.slot_index] = r.set_runnable;
      slot_tickets[r.slot_index]  = r.set_tickets;
      return 1'b0;
    end
    for (i = 0; i < lsch_pkg::SLOT_COUNT; i++) begin
      if (slot_runnable[i]) total += slot_tickets[i];
    end
    if (total == 0) return 1'b1;
    pick = r.random_value % total + 1;
    for (i = 0; i < lsch_pkg::SLOT_COUNT; i++) begin
      if (slot_runnable[i]) begin
        if (pick <= slot_tickets[i]) begin
          slot_runnable[i] = 1'b0;
          slot_picks[i]    = slot_picks[i] + 1'b1;
          g.granted        = 1'b1;
          g.winner_slot    = i[lsch_pkg::IDX_W-1:0];
          g.winner_count   = slot_picks[i];
          g.ticket_total   = total[lsch_pkg::TOTAL_W-1:0];
          return 1'b1;
        end
        pick -= slot_tickets[i];
      end
    end
    g.ticket_total = total[lsch_pkg::TOTAL_W-1:0];
    return 1'b1;
  endfunction

  // random request shaped by the current mix
  function automatic sched_req_t make_request(input mix_t mix, input int j);
    sched_req_t r;
    r.req_type     = ($urandom_range(0, 1) == 1) ? lsch_pkg::REQ_DRAW : lsch_pkg::REQ_WRITE;
    r.slot_index   = lsch_pkg::IDX_W'($urandom_range(0, lsch_pkg::SLOT_COUNT - 1));
    r.set_runnable = ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 5))
      0:       r.set_tickets = '0;
      1:       r.set_tickets = '1;
      2, 3:    r.set_tickets = lsch_pkg::TKT_W'($urandom_range(1, 15));
      default: r.set_tickets = lsch_pkg::TKT_W'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 7))
      0:       r.random_value = '0;
      1:       r.random_value = '1;
      default: r.random_value = lsch_pkg::RAND_W'($urandom_range(0, 65535));
    endcase
    case (mix)
      MIX_SPARSE: begin
        r.req_type    = ($urandom_range(0, 9) < 4) ? lsch_pkg::REQ_DRAW : lsch_pkg::REQ_WRITE;
        r.slot_index  = lsch_pkg::IDX_W'($urandom_range(0, 7));
        r.set_tickets = lsch_pkg::TKT_W'($urandom_range(0, 8));
      end
      MIX_HEAVY: begin
        // mostly draws, the first two always
        if (j < 2 || $urandom_range(0, 3) != 0) begin
          r.req_type = lsch_pkg::REQ_DRAW;
        end else begin
          r.req_type = lsch_pkg::REQ_WRITE;
        end
      end
      MIX_FILL: begin
        // every slot runnable with full tickets, then draws
        if (j < lsch_pkg::SLOT_COUNT) begin
          r.req_type     = lsch_pkg::REQ_WRITE;
          r.slot_index   = lsch_pkg::IDX_W'(j);
          r.set_runnable = 1'b1;
          r.set_tickets  = '1;
        end else begin
          r.req_type = lsch_pkg::REQ_DRAW;
        end
      end
      MIX_NOISE: begin
        r.set_runnable = ($urandom_range(0, 1) == 1);
        r.set_tickets  = lsch_pkg::TKT_W'($urandom_range(0, 255));
      end
      default: ;
    endcase
    return r;
  endfunction

  // offer one request and record what it should produce once taken
  task automatic push_request(input sched_req_t r, input logic fixed, input grant_t want);
    int     gap;
    grant_t g;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= r.req_type;
    req_bus.slot_index   <= r.slot_index;
    req_bus.set_runnable <= r.set_runnable;
    req_bus.set_tickets  <= r.set_tickets;
    req_bus.random_value <= r.random_value;
    do @(posedge clk); while (!req_bus.ready);
    if (run_lottery(r, g)) pending_grants.push_back(fixed ? want : g);
    issued++;
  endtask

  // stop offering until every grant has come back
  task automatic wait_for_drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_grants.size() != 0);
  endtask

  // stimulus
  initial begin : stimulus
    mix_t mix;
    int   k;
    int   j;
    req_bus.valid        <= 1'b0;
    req_bus.req_type     <= lsch_pkg::REQ_WRITE;
    req_bus.slot_index   <= '0;
    req_bus.set_runnable <= 1'b0;
    req_bus.set_tickets  <= '0;
    req_bus.random_value <= '0;
    rst                  <= 1'b1;
    for (k = 0; k < lsch_pkg::SLOT_COUNT; k++) begin
      slot_runnable[k] = 1'b0;
      slot_tickets[k]  = '0;
      slot_picks[k]    = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < DIR_ROWS; k++) begin
      push_request(dir_tab[k].req, dir_tab[k].fixed, dir_tab[k].want);
    end
    wait_for_drain();

    // long receiver stall while draws keep coming, so the input backs up
    hold_request = 1'b1;
    for (k = 0; k < 10; k++) begin
      push_request(make_request(MIX_HEAVY, k), 1'b0, NO_GRANT);
    end
    wait_for_drain();

    // random phases, each with a randomly chosen mix of writes and draws
    while (issued < ITEM_TARGET) begin
      mix = mix_t'($urandom_range(0, 3));
      for (j = 0; j < PHASE_ITEMS && issued < ITEM_TARGET; j++) begin
        if (issued >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
        push_request(make_request(mix, j), 1'b0, NO_GRANT);
      end
      if (!calm && $urandom_range(0, 2) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // grant receiver: random stalls, one long hold on request
  initial begin : grant_sink
    int n;
    bit held;
    held = 1'b0;
    rsp_bus.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_request && !held) begin
        held = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_bus.ready <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n) @(posedge clk);
      end else begin
        rsp_bus.ready <= 1'b1;
        n = $urandom_range(1, 24);
        repeat (n) @(posedge clk);
      end
    end
  end

  // compare each grant with the oldest one waiting
  always @(posedge clk) begin : grant_check
    grant_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("response with nothing pending, slot",
                        64'(rsp_bus.winner_slot), 64'(0));
      end else begin
        want = pending_grants.pop_front();
        if (rsp_bus.granted !== want.granted)
          report_mismatch("granted", 64'(rsp_bus.granted), 64'(want.granted));
        if (rsp_bus.winner_slot !== want.winner_slot)
          report_mismatch("winner_slot", 64'(rsp_bus.winner_slot), 64'(want.winner_slot));
        if (rsp_bus.winner_count !== want.winner_count)
          report_mismatch("winner_count", 64'(rsp_bus.winner_count),
                          64'(want.winner_count));
        if (rsp_bus.ticket_total !== want.ticket_total)
          report_mismatch("ticket_total", 64'(rsp_bus.ticket_total),
                          64'(want.ticket_total));
      end
    end
  end

  // hard stop
  initial begin : watchdog
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
rtl/lsch_pkg.sv
rtl/lsch_if.sv
rtl/lsch_slot_mem.sv
rtl/lsch_mod_unit.sv
rtl/lottery_scheduler_core.sv
test/testbench.sv
